// ----- src/input_scan_byte_schedule_macros.svh -----
// Assertion macros for the input scan byte schedule block.
`ifndef INPUT_SCAN_BYTE_SCHEDULE_MACROS_SVH
`define INPUT_SCAN_BYTE_SCHEDULE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ISBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isbs same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ISBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isbs next-cycle check failed");

`endif

// ----- src/isbs_pkg.sv -----
// Package: microcode layout, byte constants and control word for the byte scheduler.
package isbs_pkg;

	localparam int TABLE_ENTRIES_DEF = 30;
	localparam int BANK_COUNT_DEF    = 2;

	localparam int SETUP_LEN = 21;
	localparam int HEAD_LEN  = 9;
	localparam int TAIL_LEN  = 5;

	localparam int OPEN_BASE  = 1;
	localparam int HEAD_BASE  = OPEN_BASE + SETUP_LEN;
	localparam int CPAIR_BASE = HEAD_BASE + HEAD_LEN;
	localparam int WPAIR_BASE = CPAIR_BASE + 10;
	localparam int TAIL_BASE  = WPAIR_BASE + 10;
	localparam int CLOSE_BASE = TAIL_BASE + TAIL_LEN;
	localparam int UC_LEN     = CLOSE_BASE + SETUP_LEN;
	localparam int UPC_W      = $clog2(UC_LEN);

	localparam logic [7:0] PAIR_LO  = 8'h51;
	localparam logic [7:0] PAIR_HI  = 8'hd1;
	localparam logic [7:0] BIT_MARK = 8'h20;

	localparam logic [7:0] OPEN_SEQ [SETUP_LEN] = '{
		8'h11, 8'h11, 8'h51, 8'hd1, 8'h71, 8'hf1, 8'h51,
		8'hd1, 8'h51, 8'hd1, 8'h71, 8'hf1, 8'h51, 8'hd1,
		8'h51, 8'hd1, 8'h51, 8'hd1, 8'h51, 8'hd1, 8'h51
	};

	localparam logic [7:0] CLOSE_SEQ [SETUP_LEN] = '{
		8'h11, 8'h11, 8'h51, 8'hd1, 8'h71, 8'hf1, 8'h51,
		8'hd1, 8'h51, 8'hd1, 8'h51, 8'hd1, 8'h51, 8'hd1,
		8'h51, 8'hd1, 8'h51, 8'hd1, 8'h51, 8'hd1, 8'h51
	};

	localparam logic [7:0] HEAD_SEQ [HEAD_LEN] = '{
		8'h11, 8'h11, 8'h51, 8'hd1, 8'h71, 8'hf1, 8'h51, 8'hd1, 8'h71
	};

	localparam logic [7:0] TAIL_SEQ [TAIL_LEN] = '{
		8'h01, 8'h01, 8'h51, 8'hd1, 8'h51
	};

	typedef enum logic [1:0] {
		OP_BRANCH,
		OP_LIT,
		OP_CNT_PAIR,
		OP_WORD_PAIR
	} uop_t;

	typedef struct packed {
		uop_t             op;
		logic [7:0]       lit;
		logic [3:0]       sel;
		logic [UPC_W-1:0] target;
		logic             last;
		logic             closing;
	} ucw_t;

	function automatic ucw_t ucode(input logic [UPC_W-1:0] a);
		ucw_t w;
		int   k;
		w.op      = OP_LIT;
		w.lit     = 8'h00;
		w.sel     = 4'd0;
		w.target  = '0;
		w.last    = 1'b0;
		w.closing = 1'b0;
		k         = int'(a);
		if (k == 0) begin
			w.op     = OP_BRANCH;
			w.target = UPC_W'(CLOSE_BASE);
		end else if (k < HEAD_BASE) begin
			w.lit = OPEN_SEQ[k - OPEN_BASE];
		end else if (k < CPAIR_BASE) begin
			w.lit = HEAD_SEQ[k - HEAD_BASE];
		end else if (k < WPAIR_BASE) begin
			w.op  = OP_CNT_PAIR;
			w.lit = ((k - CPAIR_BASE) & 1) != 0 ? PAIR_HI : PAIR_LO;
			w.sel = 4'(5 + ((k - CPAIR_BASE) >> 1));
		end else if (k < TAIL_BASE) begin
			w.op  = OP_WORD_PAIR;
			w.lit = ((k - WPAIR_BASE) & 1) != 0 ? PAIR_HI : PAIR_LO;
			w.sel = 4'(15 - ((k - WPAIR_BASE) >> 1));
		end else if (k < CLOSE_BASE) begin
			w.lit  = TAIL_SEQ[k - TAIL_BASE];
			w.last = (k == CLOSE_BASE - 1);
		end else if (k < UC_LEN) begin
			w.lit     = CLOSE_SEQ[k - CLOSE_BASE];
			w.closing = 1'b1;
			w.last    = (k == UC_LEN - 1);
		end else begin
			w.last = 1'b1;
		end
		return w;
	endfunction

endpackage

// ----- src/input_scan_byte_schedule.sv -----
// A write beat is absorbed into the table; a run beat shows its first byte after acceptance
// through one dispatch step, then the output register, once the output side is free.
// A run emits one byte per cycle from the microcode step counter while output keeps up.
// Reset clears the frame counter, the sequencer and the output valid; the table is undefined
// until written.
`include "input_scan_byte_schedule_macros.svh"

module input_scan_byte_schedule #(
	parameter int TABLE_ENTRIES = isbs_pkg::TABLE_ENTRIES_DEF,
	parameter int BANK_COUNT    = isbs_pkg::BANK_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [4:0]  entry_address,
	input  logic [15:0] entry_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        closing_run
);
	import isbs_pkg::*;

	localparam int FRAME_TOTAL = TABLE_ENTRIES * BANK_COUNT;
	localparam int CNT_W       = $clog2(FRAME_TOTAL + 1);
	localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [15:0]      mem [TABLE_ENTRIES];
	logic [15:0]      word_q;
	logic [CNT_W-1:0] cnt_q;
	logic [UPC_W-1:0] step_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             closing_q;

	ucw_t             uc;
	logic             in_acc;
	logic             wr_en;
	logic             wrap;
	logic [CNT_W-1:0] rd_cnt;
	logic [IDX_W-1:0] rd_idx;
	logic [15:0]      src;
	logic             sel_bit;
	logic [7:0]       byte_d;
	logic             emit;

	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;
	assign wr_en    = in_acc && !command && ({1'b0, entry_address} < 6'(TABLE_ENTRIES));
	assign wrap     = (cnt_q >= CNT_W'(FRAME_TOTAL));
	assign rd_cnt   = (cnt_q >= CNT_W'(TABLE_ENTRIES)) ? cnt_q - CNT_W'(TABLE_ENTRIES) : cnt_q;
	assign rd_idx   = IDX_W'(rd_cnt);

	always_comb begin
		uc      = ucode(step_q);
		src     = (uc.op == OP_CNT_PAIR) ? 16'(cnt_q) : word_q;
		sel_bit = src[uc.sel];
		byte_d  = uc.lit;
		if ((uc.op == OP_CNT_PAIR || uc.op == OP_WORD_PAIR) && sel_bit) begin
			byte_d = uc.lit | BIT_MARK;
		end
		emit = busy_q && (uc.op != OP_BRANCH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[entry_address[IDX_W-1:0]] <= entry_value;
		end
		if (in_acc && command) begin
			word_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (in_acc && command) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (uc.op == OP_BRANCH) begin
			step_q <= wrap ? uc.target : step_q + 1'b1;
		end else if (emit) begin
			step_q <= step_q + 1'b1;
			if (uc.last) begin
				busy_q <= 1'b0;
				cnt_q  <= uc.closing ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_d;
			last_q     <= uc.last;
			closing_q  <= uc.closing;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign closing_run = closing_q;

	`ISBS_ASSERT_NEXT(a_run_starts_dispatch, in_acc && command, busy_q && step_q == '0)
	`ISBS_ASSERT_NEXT(a_last_ends_run, emit && uc.last, !busy_q && out_valid_q && last_q)
	`ISBS_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_q <= CNT_W'(FRAME_TOTAL))
	`ISBS_ASSERT_NOW(a_closing_only_on_wrap, emit && uc.closing, wrap)

endmodule
